@@ rtl/core/ffca_pkg.sv @@
// Shared widths and types for the first-fit capacity allocator.
package ffca_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned SlotW     = 10;
  localparam int unsigned SlotNumW  = 11;
  localparam int unsigned InTdataW  = 48;
  localparam int unsigned OutTdataW = 16;

  // Results of the shared subtract/compare unit
  typedef struct packed {
    logic             ge;
    logic [DataW-1:0] max;
    logic [DataW-1:0] diff;
  } ffca_alu_res_t;

endpackage

@@ rtl/core/first_fit_capacity_allocator_core.sv @@
// First-fit capacity allocator: max segment tree walked by a small sequencer.
//
// Input stream (s_axis): tuser = req_type (0 set, 1 allocate), tdata carries
// slot_index and amount. Output stream (m_axis): one transfer per input item,
// tuser = granted, tdata = 1-based slot number (0 when nothing allocated).
//
// One item at a time. With L = leaves (NUM_SLOTS rounded up to a power of
// two) and D = log2(L), the steps from the accept onward are:
//   allocate: accept, root compare, D descent steps, leaf subtract, sibling
//             fetch, D ancestor rewrites, result load; a failed allocate
//             goes from the root compare straight to the result load.
//   set:      accept with leaf write, sibling fetch, D ancestor rewrites,
//             result load; a slot beyond NUM_SLOTS goes from accept to result load.
// One tree level per cycle each way: one compare unit, one write port.
//
// After reset the block sweeps the node store to zero, one node a cycle, over
// all 2*L nodes (2048 at the default), with s_axis_tready low. The result sits
// in an output register; the next item is taken while it waits, and the
// sequencer only holds in its final step if a second result is ready before
// the receiver takes the first.
module first_fit_capacity_allocator_core #(
  parameter int NUM_SLOTS = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [ffca_pkg::InTdataW-1:0] s_axis_tdata,  // slot_index[9:0], amount[41:10]
  input  logic                          s_axis_tuser,  // req_type
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [ffca_pkg::OutTdataW-1:0] m_axis_tdata, // slot_number[10:0]
  output logic                          m_axis_tuser   // granted
);
  import ffca_pkg::*;

  localparam int Levels = $clog2(NUM_SLOTS);
  localparam int Leaves = 1 << Levels;
  localparam int AddrW  = Levels + 1;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_ROOT, ST_DESC, ST_LEAF, ST_UP, ST_UPW, ST_DONE
  } state_t;

  state_t               state, state_next;
  logic [AddrW-1:0]     clr_addr, clr_addr_next;
  logic [AddrW-1:0]     node, node_next;
  logic [DataW-1:0]     val, val_next;
  logic [DataW-1:0]     req_amt, req_amt_next;
  logic                 res_granted, res_granted_next;
  logic [SlotNumW-1:0]  res_slot, res_slot_next;
  logic                 m_valid, m_valid_next;
  logic                 m_granted, m_granted_next;
  logic [SlotNumW-1:0]  m_slot, m_slot_next;

  logic                 we;
  logic [AddrW-1:0]     waddr, raddr_a, raddr_b;
  logic [DataW-1:0]     wdata, rd_a, rd_b;
  logic [DataW-1:0]     alu_a, alu_b;
  ffca_alu_res_t        alu_res;

  logic                 accept;
  logic [SlotW-1:0]     in_slot;
  logic [DataW-1:0]     in_amount;
  logic [AddrW-1:0]     child, parent;

  assign in_slot   = s_axis_tdata[SlotW-1:0];
  assign in_amount = s_axis_tdata[SlotW +: DataW];
  assign s_axis_tready = (state == ST_IDLE);
  assign accept    = s_axis_tvalid && s_axis_tready;

  assign child  = {node[AddrW-2:0], ~alu_res.ge};
  assign parent = node >> 1;

  ffca_tree_mem #(.AddrW(AddrW)) u_mem (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  ffca_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  always_comb begin
    state_next       = state;
    clr_addr_next    = clr_addr;
    node_next        = node;
    val_next         = val;
    req_amt_next     = req_amt;
    res_granted_next = res_granted;
    res_slot_next    = res_slot;
    m_valid_next     = m_valid;
    m_granted_next   = m_granted;
    m_slot_next      = m_slot;
    we      = 1'b0;
    waddr   = node;
    wdata   = alu_res.diff;
    raddr_a = node;
    raddr_b = node;
    alu_a   = val;
    alu_b   = req_amt;

    if (m_valid && m_axis_tready) begin
      m_valid_next = 1'b0;
    end

    case (state)
      ST_CLEAR: begin
        we            = 1'b1;
        waddr         = clr_addr;
        wdata         = '0;
        clr_addr_next = clr_addr + AddrW'(1);
        if (clr_addr == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          req_amt_next     = in_amount;
          res_granted_next = 1'b0;
          res_slot_next    = '0;
          if (s_axis_tuser) begin
            raddr_a    = AddrW'(1);
            state_next = ST_ROOT;
          end else if (32'(in_slot) < 32'(NUM_SLOTS)) begin
            we         = 1'b1;
            waddr      = AddrW'(Leaves) + AddrW'(in_slot);
            wdata      = in_amount;
            node_next  = AddrW'(Leaves) + AddrW'(in_slot);
            val_next   = in_amount;
            state_next = ST_UP;
          end else begin
            state_next = ST_DONE;  // slot beyond NUM_SLOTS: nothing changes
          end
        end
      end
      ST_ROOT: begin
        alu_a = rd_a;
        if (alu_res.ge) begin
          node_next  = AddrW'(1);
          raddr_a    = AddrW'(2);
          raddr_b    = AddrW'(3);
          state_next = ST_DESC;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DESC: begin
        // left child wins whenever it suffices
        alu_a     = rd_a;
        node_next = child;
        val_next  = alu_res.ge ? rd_a : rd_b;
        if (child[AddrW-1]) begin
          state_next = ST_LEAF;
        end else begin
          raddr_a = {child[AddrW-2:0], 1'b0};
          raddr_b = {child[AddrW-2:0], 1'b1};
        end
      end
      ST_LEAF: begin
        we               = 1'b1;
        waddr            = node;
        wdata            = alu_res.diff;
        val_next         = alu_res.diff;
        res_granted_next = 1'b1;
        res_slot_next    = SlotNumW'({1'b0, node[Levels-1:0]} + (Levels + 1)'(1));
        state_next       = ST_UP;
      end
      ST_UP: begin
        if (node == AddrW'(1)) begin
          state_next = ST_DONE;
        end else begin
          raddr_a    = node ^ AddrW'(1);
          state_next = ST_UPW;
        end
      end
      ST_UPW: begin
        // sibling arrives on port A; parent gets the larger of the pair
        alu_b     = rd_a;
        we        = 1'b1;
        waddr     = parent;
        wdata     = alu_res.max;
        val_next  = alu_res.max;
        node_next = parent;
        if (parent == AddrW'(1)) begin
          state_next = ST_DONE;
        end else begin
          raddr_a = parent ^ AddrW'(1);
        end
      end
      ST_DONE: begin
        if (!m_valid || m_axis_tready) begin
          m_valid_next   = 1'b1;
          m_granted_next = res_granted;
          m_slot_next    = res_slot;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      m_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      m_valid  <= m_valid_next;
    end
    node        <= node_next;
    val         <= val_next;
    req_amt     <= req_amt_next;
    res_granted <= res_granted_next;
    res_slot    <= res_slot_next;
    m_granted   <= m_granted_next;
    m_slot      <= m_slot_next;
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tuser  = m_granted;
  assign m_axis_tdata  = OutTdataW'(m_slot);

  // when the left child falls short, the right one must cover the request
  a_desc_right_fits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DESC) && !alu_res.ge |-> rd_b >= req_amt)
    else $error("descent found neither child sufficient");

  a_leaf_fits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LEAF) |-> alu_res.ge)
    else $error("chosen leaf below requested amount");

  a_fail_zero_slot: assert property (@(posedge clk) disable iff (rst)
    m_valid && !m_granted |-> m_slot == '0)
    else $error("slot number reported without a grant");

  a_grant_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_valid && m_granted && (NUM_SLOTS <= 2047) |-> m_slot != '0)
    else $error("grant with zero slot number");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_axis_tready)
    else $error("second transfer taken while an item is in work");

endmodule

@@ rtl/core/ffca_alu.sv @@
// Shared 32-bit subtractor: one borrow chain gives compare, max and difference.
module ffca_alu (
  input  logic [ffca_pkg::DataW-1:0] a,
  input  logic [ffca_pkg::DataW-1:0] b,
  output ffca_pkg::ffca_alu_res_t    res
);
  import ffca_pkg::*;

  logic [DataW:0] d;

  assign d        = {1'b0, a} - {1'b0, b};
  assign res.ge   = ~d[DataW];
  assign res.diff = d[DataW-1:0];
  assign res.max  = res.ge ? a : b;

endmodule

@@ rtl/core/ffca_tree_mem.sv @@
// Segment tree node store: one write port, two registered read ports.
module ffca_tree_mem #(
  parameter int AddrW = 11
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AddrW-1:0]          waddr,
  input  logic [ffca_pkg::DataW-1:0] wdata,
  input  logic [AddrW-1:0]          raddr_a,
  input  logic [AddrW-1:0]          raddr_b,
  output logic [ffca_pkg::DataW-1:0] rdata_a,
  output logic [ffca_pkg::DataW-1:0] rdata_b
);
  import ffca_pkg::*;

  localparam int Depth = 1 << AddrW;

  logic [DataW-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ verif/tb_first_fit_capacity_allocator_core.sv @@
// Stream-level testbench for the first-fit capacity allocator core with a scoreboard.
module tb_first_fit_capacity_allocator_core;
  import ffca_pkg::*;

  localparam int unsigned NUM_SLOTS         = 1024;
  localparam int unsigned CYCLE_LIMIT       = 400000;
  localparam int unsigned SETTLE_CYCLES     = 64;
  localparam int unsigned SINK_HOLD_CYCLES  = 400;
  localparam int unsigned IDLE_PCT          = 26;
  localparam int unsigned WINDOW_SLOTS      = 16;
  localparam int unsigned TDATA_PAD         = InTdataW - SlotW - DataW;

  typedef enum logic {
    REQ_SET   = 1'b0,
    REQ_ALLOC = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic                granted;
    logic [SlotNumW-1:0] slot_number;
  } grant_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 m_axis_tuser;

  // Remaining capacity per slot, as the allocator should hold it
  logic [DataW-1:0] slot_cap [NUM_SLOTS];
  grant_t           expected_grants [$];

  int unsigned source_idle_pct = IDLE_PCT;
  int unsigned sink_idle_pct   = IDLE_PCT;
  logic        sink_hold       = 1'b0;
  int unsigned window_base     = 0;
  int unsigned fail_count      = 0;
  int unsigned cycle_count     = 0;

  first_fit_capacity_allocator_core #(
    .NUM_SLOTS(NUM_SLOTS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Leftmost slot with enough room wins; a failed request leaves the slots alone
  function automatic grant_t predict_grant(input req_kind_t kind, input logic [SlotW-1:0] slot,
                                           input logic [DataW-1:0] amt);
    grant_t      g;
    int unsigned i;
    logic        hit;
    g.granted     = 1'b0;
    g.slot_number = '0;
    if (kind == REQ_SET) begin
      if (slot < NUM_SLOTS) slot_cap[slot] = amt;
    end else begin
      i   = 0;
      hit = 1'b0;
      while (!hit && i < NUM_SLOTS) begin
        if (slot_cap[i] >= amt) begin
          hit = 1'b1;
        end else begin
          i++;
        end
      end
      if (hit) begin
        slot_cap[i]   = slot_cap[i] - amt;
        g.granted     = 1'b1;
        g.slot_number = SlotNumW'(i + 1);
      end
    end
    return g;
  endfunction

  // Sink side: random stalls, or a solid hold-off while sink_hold is set
  always @(posedge clk) begin
    if (sink_hold) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    grant_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_grants.size() == 0) begin
        $error("unexpected result transfer: granted %0d slot_number %0d",
               m_axis_tuser, m_axis_tdata[SlotNumW-1:0]);
        fail_count++;
      end else begin
        want = expected_grants.pop_front();
        if (m_axis_tuser !== want.granted) begin
          $error("granted: expected %0d, got %0d", want.granted, m_axis_tuser);
          fail_count++;
        end
        if (m_axis_tdata[SlotNumW-1:0] !== want.slot_number) begin
          $error("slot_number: expected %0d, got %0d", want.slot_number,
                 m_axis_tdata[SlotNumW-1:0]);
          fail_count++;
        end
      end
    end
  end

  // Returns right after the accepting edge with tvalid still high, so a
  // back-to-back transfer needs no second assignment in this step.
  task automatic send_request(input req_kind_t kind, input logic [SlotW-1:0] slot,
                              input logic [DataW-1:0] amt);
    grant_t want;
    while ($urandom_range(99) < source_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {{TDATA_PAD{1'b0}}, amt, slot};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    want = predict_grant(kind, slot, amt);
    expected_grants.push_back(want);
  endtask

  function automatic logic [SlotW-1:0] pick_slot();
    if ($urandom_range(99) < 70) return SlotW'(window_base + $urandom_range(WINDOW_SLOTS - 1));
    return SlotW'($urandom);
  endfunction

  function automatic logic [DataW-1:0] pick_capacity();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return $urandom_range(1000);
    if (r < 70) return '0;
    if (r < 90) return $urandom;
    return '1;
  endfunction

  function automatic logic [DataW-1:0] pick_amount();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return $urandom_range(400);
    if (r < 65) return '0;
    if (r < 80) return $urandom;
    if (r < 90) return $urandom_range(8, 1);
    // exact fit on a slot that is probably in use
    return slot_cap[window_base + $urandom_range(WINDOW_SLOTS - 1)];
  endfunction

  task automatic test_empty_tree();
    send_request(REQ_ALLOC, '0, '0);
    send_request(REQ_ALLOC, '1, 32'd1);
    send_request(REQ_ALLOC, '0, '1);
    send_request(REQ_SET, '0, '0);
  endtask

  task automatic test_slot_extremes();
    send_request(REQ_SET, '1, '1);
    send_request(REQ_ALLOC, '0, '1);
    send_request(REQ_ALLOC, '0, 32'd1);
    send_request(REQ_SET, '1, 32'd7);
    send_request(REQ_SET, '0, 32'd3);
    send_request(REQ_ALLOC, '1, 32'd5);
    send_request(REQ_ALLOC, '0, 32'd3);
    send_request(REQ_ALLOC, '1, '0);
    send_request(REQ_ALLOC, '0, 32'd2);
  endtask

  // Unequal capacities on either side of the tree's midpoint, then a tight fit
  task automatic test_first_fit_order();
    send_request(REQ_SET, 10'd511, 32'd50);
    send_request(REQ_SET, 10'd512, 32'd80);
    send_request(REQ_ALLOC, '0, 32'd60);
    send_request(REQ_ALLOC, '0, 32'd50);
    send_request(REQ_ALLOC, '0, 32'd20);
    send_request(REQ_ALLOC, '0, 32'd1);
    send_request(REQ_SET, 10'd5, 32'h8000_0000);
    send_request(REQ_ALLOC, '1, 32'h7FFF_FFFF);
    send_request(REQ_ALLOC, '0, 32'd2);
  endtask

  task automatic run_random(input int unsigned n_items);
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 100 == 0) window_base = $urandom_range(NUM_SLOTS - WINDOW_SLOTS);
      if ($urandom_range(99) < 35) begin
        send_request(REQ_SET, pick_slot(), pick_capacity());
      end else begin
        send_request(REQ_ALLOC, SlotW'($urandom), pick_amount());
      end
    end
  endtask

  task automatic test_random_mix();
    source_idle_pct = 0;
    sink_idle_pct  <= 0;
    run_random(250);
    source_idle_pct = IDLE_PCT;
    sink_idle_pct  <= IDLE_PCT;
    run_random(800);
  endtask

  // Sink stops taking results while the source keeps offering, so the core
  // has to fill its output register and drop s_axis_tready.
  task automatic test_backpressure();
    source_idle_pct = 0;
    fork
      begin
        sink_hold <= 1'b1;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
        sink_hold <= 1'b0;
      end
    join_none
    run_random(70);
    source_idle_pct = IDLE_PCT;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    foreach (slot_cap[i]) slot_cap[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // the core clears its node store first; send_request waits on tready
    test_empty_tree();
    test_slot_extremes();
    test_first_fit_order();
    test_random_mix();
    test_backpressure();
    drain_results();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/ffca_pkg.sv
rtl/core/ffca_alu.sv
rtl/core/ffca_tree_mem.sv
rtl/core/first_fit_capacity_allocator_core.sv
verif/tb_first_fit_capacity_allocator_core.sv
